>>> rtl/sorted_set_range_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// Sorted set range encoder assertion macros
// Shared property forms for the encoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_RANGE_ENCODER_TOP_DEFINES_SVH
`define SORTED_SET_RANGE_ENCODER_TOP_DEFINES_SVH

// implication checked outside reset
`define SSRE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, reset included
`define SSRE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ssre_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set range encoder package
// Types, widths and codes shared by the front, back and top level.
// ----------------------------------------------------------------------------
package ssre_pkg;

   localparam int SHARED_DEPTH = 4096;
   localparam int ADDR_W       = $clog2(SHARED_DEPTH);
   localparam int CNT_W        = ADDR_W + 1;
   localparam int VAL_W        = 32;
   localparam int POS_W        = 15;
   localparam int KIND_W       = 2;
   localparam int LEN_W        = 3;
   localparam int IN_TDATA_W   = 32;
   localparam int OUT_TDATA_W  = 64;
   localparam int OUT_TUSER_W  = 2;
   localparam int NUM_CAND     = 5;
   localparam int MAX_RES      = 3;

   localparam logic [VAL_W-1:0] NO_VALUE = '1;

   localparam logic [KIND_W-1:0] IN_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] IN_OFFSET = 2'd1;
   localparam logic [KIND_W-1:0] IN_END    = 2'd2;

   localparam logic [KIND_W-1:0] RK_RANGE = 2'd0;
   localparam logic [KIND_W-1:0] RK_EXTRA = 2'd1;
   localparam logic [KIND_W-1:0] RK_END   = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_OFFSET,
      OP_END,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [VAL_W-1:0]   value;
      logic               last;
      logic [LEN_W-1:0]   vlen;
   } item_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [POS_W-1:0]   rbegin;
      logic [POS_W-1:0]   rend;
      logic [VAL_W-1:0]   extra;
      logic               flag;
   } result_type;

   typedef struct packed {
      logic [VAL_W-1:0]   value;
      logic [POS_W-1:0]   start;
   } entry_type;

   function automatic logic [LEN_W-1:0] varint_len(input logic [VAL_W-1:0] v);
      logic [LEN_W-1:0] len;
      if (v < 32'd128)              len = 3'd1;
      else if (v < 32'd16384)       len = 3'd2;
      else if (v < 32'd2097152)     len = 3'd3;
      else if (v < 32'd268435456)   len = 3'd4;
      else                          len = 3'd5;
      return len;
   endfunction

endpackage

>>> rtl/ssre_front.sv
// ----------------------------------------------------------------------------
// Sorted set range encoder front
// Accepts request transfers, decodes kind and varint size, queues two items.
// ----------------------------------------------------------------------------
module ssre_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ssre_pkg::IN_TDATA_W-1:0] req_tdata,
   input  logic [ssre_pkg::KIND_W-1:0]     req_tuser,
   input  logic                            req_tlast,
   output ssre_pkg::item_type              item,
   output logic                            item_valid,
   input  logic                            item_ready
);
   import ssre_pkg::*;

   item_type   q_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   item_type   cls_in;
   logic       push;
   logic       pop;

   always_comb begin
      cls_in.value = req_tdata;
      cls_in.last  = req_tlast;
      cls_in.vlen  = varint_len(req_tdata);
      case (req_tuser)
         IN_LOAD:   cls_in.op = OP_LOAD;
         IN_OFFSET: cls_in.op = OP_OFFSET;
         IN_END:    cls_in.op = OP_END;
         default:   cls_in.op = OP_NONE;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign item_valid = (cnt_ff != 2'd0);
   assign pop        = item_valid && item_ready;
   assign item       = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cls_in;
   end

endmodule

>>> rtl/ssre_back.sv
// ----------------------------------------------------------------------------
// Sorted set range encoder back
// Holds the shared list, runs the merge sequencer and drives result transfers.
// ----------------------------------------------------------------------------
module ssre_back (
   input  logic                             clock,
   input  logic                             reset,
   input  ssre_pkg::item_type               item,
   input  logic                             item_valid,
   output logic                             item_ready,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ssre_pkg::OUT_TDATA_W-1:0] rsp_tdata,
   output logic [ssre_pkg::OUT_TUSER_W-1:0] rsp_tuser,
   output logic                             rsp_tlast
);
   import ssre_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOP,
      ST_ADV,
      ST_ENDRD,
      ST_DRAIN
   } state_type;

   entry_type         mem [SHARED_DEPTH];
   entry_type         rd_ff;
   logic              we;
   logic [ADDR_W-1:0] waddr;
   entry_type         wdata;

   state_type         state_ff, state_in;
   logic              load_open_ff, load_open_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  bytes_ff, bytes_in;
   logic [CNT_W-1:0]  ridx_ff, ridx_in;
   logic [VAL_W-1:0]  cur_ff, cur_in;
   logic [POS_W-1:0]  cur_start_ff, cur_start_in;
   logic [VAL_W-1:0]  pend_ff, pend_in;
   logic              in_range_ff, in_range_in;
   logic [POS_W-1:0]  run_start_ff, run_start_in;
   logic [VAL_W-1:0]  v_ff, v_in;
   logic              b3_ff, b3_in;
   result_type        buf_ff [MAX_RES];
   result_type        buf_in [MAX_RES];
   logic [1:0]        bcnt_ff, bcnt_in;
   logic [1:0]        bidx_ff, bidx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   result_type        cand   [NUM_CAND];
   logic              cand_v [NUM_CAND];
   logic              out_free;

   function automatic result_type mk(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] b,
                                     input logic [POS_W-1:0] e, input logic [VAL_W-1:0] x,
                                     input logic f);
      result_type r;
      r.kind   = k;
      r.rbegin = b;
      r.rend   = e;
      r.extra  = x;
      r.flag   = f;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[ridx_ff[ADDR_W-1:0]];
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign item_ready = (state_ff == ST_IDLE);

   always_comb begin
      logic [CNT_W-1:0] cnt_e;
      logic [POS_W-1:0] bytes_e;
      logic             ir;
      logic [POS_W-1:0] rs;
      logic [VAL_W-1:0] pc;
      logic [CNT_W-1:0] rn;
      logic [2:0]       j;

      state_in     = state_ff;
      load_open_in = load_open_ff;
      count_in     = count_ff;
      bytes_in     = bytes_ff;
      ridx_in      = ridx_ff;
      cur_in       = cur_ff;
      cur_start_in = cur_start_ff;
      pend_in      = pend_ff;
      in_range_in  = in_range_ff;
      run_start_in = run_start_ff;
      v_in         = v_ff;
      b3_in        = b3_ff;
      bcnt_in      = bcnt_ff;
      bidx_in      = bidx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;
      we           = 1'b0;
      waddr        = '0;
      wdata        = '0;
      cnt_e        = '0;
      bytes_e      = '0;
      ir           = in_range_ff;
      rs           = run_start_ff;
      pc           = pend_ff;
      rn           = ridx_ff;
      for (int k = 0; k < NUM_CAND; k++) begin
         cand[k]   = '0;
         cand_v[k] = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               case (item.op)
                  OP_LOAD: begin
                     cnt_e   = load_open_ff ? count_ff : '0;
                     bytes_e = load_open_ff ? bytes_ff : '0;
                     ridx_in = '0; cur_in = NO_VALUE; pend_in = NO_VALUE;
                     in_range_in = 1'b0; run_start_in = '0; cur_start_in = '0;
                     bytes_in = bytes_e;
                     count_in = cnt_e;
                     if (cnt_e < CNT_W'(SHARED_DEPTH)) begin
                        we       = 1'b1;
                        waddr    = cnt_e[ADDR_W-1:0];
                        wdata    = '{value: item.value, start: bytes_e};
                        bytes_in = bytes_e + POS_W'(item.vlen);
                        count_in = cnt_e + 1'b1;
                     end
                     load_open_in = !item.last;
                     if (item.last) begin
                        cand[0]   = mk(RK_RANGE, '0, bytes_in, '0, 1'b1);
                        cand_v[0] = 1'b1;
                        state_in  = ST_DRAIN;
                     end
                  end
                  OP_OFFSET: begin
                     v_in = item.value;
                     if (ridx_ff >= count_ff) begin
                        cand[0]   = mk(RK_EXTRA, '0, '0, item.value, 1'b0);
                        cand_v[0] = 1'b1;
                        state_in  = ST_DRAIN;
                     end else begin
                        state_in = ST_LOOP;
                     end
                  end
                  OP_END: begin
                     if (ridx_ff < count_ff) begin
                        state_in = ST_ENDRD;
                     end else begin
                        cand[0]   = mk(RK_END, '0, '0, '0, 1'b1);
                        cand_v[0] = 1'b1;
                        ridx_in = '0; cur_in = NO_VALUE; pend_in = NO_VALUE;
                        in_range_in = 1'b0; run_start_in = '0; cur_start_in = '0;
                        state_in = ST_DRAIN;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_LOOP: begin
            if (cur_ff < pend_ff) begin
               b3_in    = 1'b0;
               state_in = ST_ADV;
            end else if (pend_ff < cur_ff) begin
               pend_in = v_ff;
               if (cur_ff == v_ff) begin
                  if (!in_range_ff) begin
                     run_start_in = cur_start_ff;
                     in_range_in  = 1'b1;
                  end
               end else begin
                  if (in_range_ff) begin
                     in_range_in = 1'b0;
                     cand[0]     = mk(RK_RANGE, run_start_ff, cur_start_ff, '0, 1'b0);
                     cand_v[0]   = 1'b1;
                  end
                  if (v_ff < cur_ff) begin
                     cand[1]   = mk(RK_EXTRA, '0, '0, v_ff, 1'b0);
                     cand_v[1] = 1'b1;
                  end
               end
               state_in = ST_DRAIN;
            end else begin
               b3_in    = 1'b1;
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            cur_in       = rd_ff.value;
            cur_start_in = rd_ff.start;
            rn           = ridx_ff + 1'b1;
            ridx_in      = rn;
            pc           = b3_ff ? v_ff : pend_ff;
            pend_in      = pc;
            if (rd_ff.value == pc) begin
               if (!ir) begin
                  rs = rd_ff.start;
                  ir = 1'b1;
               end
            end else begin
               if (ir) begin
                  ir        = 1'b0;
                  cand[0]   = mk(RK_RANGE, run_start_ff, rd_ff.start, '0, 1'b0);
                  cand_v[0] = 1'b1;
               end
               if (pc < rd_ff.value) begin
                  cand[1]   = mk(RK_EXTRA, '0, '0, pc, 1'b0);
                  cand_v[1] = 1'b1;
               end
            end
            if (rn >= count_ff) begin
               if (ir) begin
                  ir        = 1'b0;
                  cand[2]   = mk(RK_RANGE, rs, bytes_ff, '0, 1'b0);
                  cand_v[2] = 1'b1;
               end
               if (pc > rd_ff.value) begin
                  cand[3]   = mk(RK_EXTRA, '0, '0, pc, 1'b0);
                  cand_v[3] = 1'b1;
               end
               if (!b3_ff) begin
                  cand[4]   = mk(RK_EXTRA, '0, '0, v_ff, 1'b0);
                  cand_v[4] = 1'b1;
               end
               state_in = ST_DRAIN;
            end else begin
               state_in = b3_ff ? ST_DRAIN : ST_LOOP;
            end
            in_range_in  = ir;
            run_start_in = rs;
         end
         ST_ENDRD: begin
            if (in_range_ff) begin
               cand[0]   = mk(RK_RANGE, run_start_ff, rd_ff.start, '0, 1'b0);
               cand_v[0] = 1'b1;
            end
            if (pend_ff > cur_ff) begin
               cand[1]   = mk(RK_EXTRA, '0, '0, pend_ff, 1'b0);
               cand_v[1] = 1'b1;
            end
            cand[2]   = mk(RK_END, '0, '0, '0, 1'b1);
            cand_v[2] = 1'b1;
            ridx_in = '0; cur_in = NO_VALUE; pend_in = NO_VALUE;
            in_range_in = 1'b0; run_start_in = '0; cur_start_in = '0;
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (bidx_ff == bcnt_ff) begin
               bidx_in  = '0;
               bcnt_in  = '0;
               state_in = ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = buf_ff[bidx_ff];
               bidx_in      = bidx_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      for (int i = 0; i < MAX_RES; i++) buf_in[i] = buf_ff[i];
      j = {1'b0, bcnt_ff};
      for (int k = 0; k < NUM_CAND; k++) begin
         if (cand_v[k] && j < 3'(MAX_RES)) begin
            buf_in[j[1:0]] = cand[k];
            j = j + 1'b1;
         end
      end
      if (state_ff != ST_DRAIN) bcnt_in = j[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         load_open_ff <= 1'b0;
         count_ff     <= '0;
         bytes_ff     <= '0;
         ridx_ff      <= '0;
         cur_ff       <= NO_VALUE;
         cur_start_ff <= '0;
         pend_ff      <= NO_VALUE;
         in_range_ff  <= 1'b0;
         run_start_ff <= '0;
         b3_ff        <= 1'b0;
         bcnt_ff      <= '0;
         bidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_open_ff <= load_open_in;
         count_ff     <= count_in;
         bytes_ff     <= bytes_in;
         ridx_ff      <= ridx_in;
         cur_ff       <= cur_in;
         cur_start_ff <= cur_start_in;
         pend_ff      <= pend_in;
         in_range_ff  <= in_range_in;
         run_start_ff <= run_start_in;
         b3_ff        <= b3_in;
         bcnt_ff      <= bcnt_in;
         bidx_ff      <= bidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff   <= v_in;
      rsp_ff <= rsp_in;
      for (int i = 0; i < MAX_RES; i++) buf_ff[i] <= buf_in[i];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.flag;
   assign rsp_tdata  = {2'b00, rsp_ff.extra, rsp_ff.rend, rsp_ff.rbegin};

endmodule

>>> rtl/sorted_set_range_encoder_top.sv
// An entry offset is merged by stepping through the shared values it passes, each with a
// memory read and a compare. A load that is not last, or an ignored kind, is taken while
// the sequencer stays idle; other items hold off the next item until their results have
// drained, and output stalls hold them further.
// The shared list sits in a single-port-read memory read at the merge index.
// Reset clears queue, sequencer and list length; list contents stay undefined.
// ----------------------------------------------------------------------------
// Sorted set range encoder top level
// Merges entry offsets against a loaded shared list into byte ranges and extras.
// ----------------------------------------------------------------------------
`include "sorted_set_range_encoder_top_defines.svh"

module sorted_set_range_encoder_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ssre_pkg::IN_TDATA_W-1:0]  req_tdata,  // value
   input  logic [ssre_pkg::KIND_W-1:0]      req_tuser,  // kind
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ssre_pkg::OUT_TDATA_W-1:0] rsp_tdata,  // range_begin, range_end, extra_offset
   output logic [ssre_pkg::OUT_TUSER_W-1:0] rsp_tuser,  // result_kind
   output logic                             rsp_tlast
);
   import ssre_pkg::*;

   item_type item;
   logic     item_valid;
   logic     item_ready;

   ssre_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .item       (item),
      .item_valid (item_valid),
      .item_ready (item_ready)
   );

   ssre_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `SSRE_ASSERT_IMP(a_last_kind, rsp_tvalid && rsp_tlast,
      rsp_tuser == RK_RANGE || rsp_tuser == RK_END, "tlast on extra")
   `SSRE_ASSERT_IMP(a_extra_zero, rsp_tvalid && rsp_tuser == RK_EXTRA,
      rsp_tdata[29:0] == 30'd0, "extra carries range")
   `SSRE_ASSERT_IMP(a_end_zero, rsp_tvalid && rsp_tuser == RK_END,
      rsp_tdata == '0 && rsp_tlast, "bad end marker")
   `SSRE_ASSERT_NEXT(a_reset_empty, reset, req_tready && !rsp_tvalid, "not empty after reset")

endmodule
